// ----- design/amed_pkg.sv -----
`default_nettype none
package amed_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int STATE_W    = 40;
  localparam int COEF_W     = 24;
  localparam int TGT_W      = 15;
  localparam int MUL_A_W    = 40;
  localparam int MUL_B_W    = 54;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int RT_IN_W    = 64;
  localparam int RT_OUT_W   = RT_IN_W / 2;
  localparam int DIV_N_W    = 54;
  localparam int DIV_D_W    = 41;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [STATE_W-1:0] STATE_ONE = 40'h40_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_COEF  = 3'd0,
    CFG_CAR_COEF = 3'd1,
    CFG_AC_COEF  = 3'd2,
    CFG_CAR_TGT  = 3'd3,
    CFG_AC_TGT   = 3'd4,
    CFG_KNEE     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] dc_coef;
    logic [COEF_W-1:0] car_coef;
    logic [COEF_W-1:0] ac_coef;
    logic [TGT_W-1:0]  car_tgt;
    logic [TGT_W-1:0]  ac_tgt;
    logic [COEF_W-1:0] knee;
  } cfg_t;

  typedef enum logic [3:0] {
    STEP_SUMI,
    STEP_SUMQ,
    STEP_MAG,
    STEP_CAR,
    STEP_DCA,
    STEP_ABS,
    STEP_CGAIN,
    STEP_SQ,
    STEP_ACP,
    STEP_ROOT,
    STEP_AGAIN,
    STEP_OUT
  } step_t;

  typedef struct packed {
    logic  start;
    step_t step;
  } dp_cmd_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_WORK,
    CT_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } ctrl_stat_t;

  typedef struct packed {
    logic in_ready;
    logic result_load;
  } ctrl_out_t;

endpackage
`default_nettype wire

// ----- design/amed_mul.sv -----
`default_nettype none
module amed_mul
  import amed_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [PROD_W-1:0]       prod
);

  localparam int CNT_W = $clog2(MUL_A_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_A_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MUL_B_W-1:0] acc_r;
  logic [MUL_A_W-1:0] lo_r;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_B_W:0]   sum;

  // Shift-add: one multiplier bit per cycle, partial sum shifts right.
  assign sum = {1'b0, acc_r} + (lo_r[0] ? {1'b0, b_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      lo_r  <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= sum[MUL_B_W:1];
      lo_r  <= {sum[0], lo_r[MUL_A_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {acc_r, lo_r};

endmodule
`default_nettype wire

// ----- design/amed_isqrt.sv -----
`default_nettype none
module amed_isqrt
  import amed_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [RT_IN_W-1:0]  x,
  output logic                     done,
  output logic [RT_OUT_W-1:0]      root
);

  localparam int CNT_W = $clog2(RT_OUT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(RT_OUT_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [RT_IN_W-1:0]  x_r;
  logic [RT_OUT_W+1:0] rem_r;
  logic [RT_OUT_W-1:0] root_r;
  logic [RT_OUT_W+3:0] rem2;
  logic [RT_OUT_W+3:0] trial;
  logic                fits;

  // Restoring square root, one result bit per cycle.
  assign rem2  = {rem_r, x_r[RT_IN_W-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign fits  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[RT_IN_W-3:0], 2'b00};
      rem_r  <= fits ? RT_OUT_W'(0) + (RT_OUT_W+2)'(rem2 - trial)
                     : (RT_OUT_W+2)'(rem2);
      root_r <= {root_r[RT_OUT_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

// ----- design/amed_div.sv -----
`default_nettype none
module amed_div
  import amed_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic                    done,
  output logic [DIV_N_W-1:0]      quo
);

  localparam int CNT_W = $clog2(DIV_N_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DIV_N_W-1:0] n_r;
  logic [DIV_D_W-1:0] d_r;
  logic [DIV_D_W-1:0] rem_r;
  logic [DIV_D_W:0]   rem2;
  logic               fits;

  // Restoring division; the quotient bits shift in where the dividend leaves.
  assign rem2 = {rem_r, n_r[DIV_N_W-1]};
  assign fits = rem2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      d_r   <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_N_W-2:0], fits};
      rem_r <= fits ? DIV_D_W'(rem2 - {1'b0, d_r}) : DIV_D_W'(rem2);
    end
  end

  assign done = done_r;
  assign quo  = n_r;

endmodule
`default_nettype wire

// ----- design/amed_ctrl.sv -----
`default_nettype none
module amed_ctrl
  import amed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctrl_stat_t stat,
  input  wire logic       dp_done,
  output dp_cmd_t         cmd,
  output ctrl_out_t       ctl
);

  ctrl_state_t state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        launched_r, launched_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CT_IDLE;
      step_r     <= STEP_SUMI;
      launched_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      launched_r <= launched_nxt;
    end
  end

  // Each step is launched once and the sequencer waits for its done pulse.
  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    launched_nxt    = launched_r;
    cmd.start       = 1'b0;
    cmd.step        = step_r;
    ctl.in_ready    = 1'b0;
    ctl.result_load = 1'b0;
    unique case (state_r)
      CT_IDLE: begin
        ctl.in_ready = 1'b1;
        if (stat.in_fire) begin
          state_nxt    = CT_WORK;
          step_nxt     = STEP_SUMI;
          launched_nxt = 1'b0;
        end
      end
      CT_WORK: begin
        if (!launched_r) begin
          cmd.start    = 1'b1;
          launched_nxt = 1'b1;
        end else if (dp_done) begin
          launched_nxt = 1'b0;
          if (step_r == STEP_OUT) begin
            state_nxt = CT_DONE;
          end else begin
            step_nxt = step_t'(step_r + 4'd1);
          end
        end
      end
      CT_DONE: begin
        if (stat.out_free) begin
          ctl.result_load = 1'b1;
          state_nxt       = CT_IDLE;
        end
      end
      default: begin
        state_nxt = CT_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/amed_dp.sv -----
`default_nettype none
module amed_dp
  import amed_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire logic                load,
  input  wire logic [SAMPLE_W-1:0] in_phase,
  input  wire logic [SAMPLE_W-1:0] quadrature,
  input  wire logic                block_end,
  input  wire dp_cmd_t             cmd,
  output logic                     done,
  output logic [SAMPLE_W-1:0]      audio_sample,
  output logic                     block_end_out
);

  logic [SAMPLE_W-1:0]   ai_r, aq_r;
  logic                  be_r;
  logic [2*SAMPLE_W-1:0] sum_r;
  logic [STATE_W-1:0]    mag_r, car_r, dca_r, acp_r, sqv_r, absval_r, root_r;
  logic                  dir_r, neg_r;
  logic [DIV_N_W-1:0]    gain_c_r, gain_r;
  logic [SAMPLE_W-1:0]   res_r;
  logic                  inst_done_r;

  logic [SAMPLE_W-1:0]   sq_op;
  logic [2*SAMPLE_W-1:0] sq_val;
  logic [STATE_W-1:0]    sm_s, sm_x, sm_diff;
  logic                  sm_up;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic                  mul_done;
  logic [PROD_W-1:0]     prod;
  logic [RT_IN_W-1:0]    rt_x;
  logic                  rt_done;
  logic [RT_OUT_W-1:0]   rt_root;
  logic [DIV_N_W-1:0]    div_n;
  logic [DIV_D_W-1:0]    div_d, den_raw, knee_s;
  logic                  div_done;
  logic [DIV_N_W-1:0]    quo;
  logic                  is_inst;

  logic [63:0]           sm_rnd;
  logic [STATE_W-1:0]    sm_step, sm_new;
  logic [80:0]           sq_rnd;
  logic [42:0]           sq_q;
  logic [PROD_W:0]       out_rnd;
  logic [PROD_W-39:0]    out_q;
  logic [SAMPLE_W-1:0]   out_lim, out_mag;

  // One narrow squarer serves both sample components in turn.
  assign sq_op  = (cmd.step == STEP_SUMI) ? ai_r : aq_r;
  assign sq_val = sq_op * sq_op;

  // Averager operands: the state being smoothed and the value it tracks.
  always_comb begin
    case (cmd.step)
      STEP_CAR: begin sm_s = car_r; sm_x = mag_r; end
      STEP_DCA: begin sm_s = dca_r; sm_x = mag_r; end
      default:  begin sm_s = acp_r; sm_x = sqv_r; end
    endcase
  end
  assign sm_up   = sm_x >= sm_s;
  assign sm_diff = sm_up ? sm_x - sm_s : sm_s - sm_x;

  always_comb begin
    case (cmd.step)
      STEP_CAR: begin mul_a = sm_diff;  mul_b = MUL_B_W'(cfg.car_coef); end
      STEP_DCA: begin mul_a = sm_diff;  mul_b = MUL_B_W'(cfg.dc_coef);  end
      STEP_ACP: begin mul_a = sm_diff;  mul_b = MUL_B_W'(cfg.ac_coef);  end
      STEP_SQ:  begin mul_a = absval_r; mul_b = MUL_B_W'(absval_r);     end
      default:  begin mul_a = absval_r; mul_b = gain_r;                 end
    endcase
  end

  // Magnitude root works on the sum scaled by 2^32; the power root by 2^22.
  assign rt_x = (cmd.step == STEP_MAG) ? {sum_r, 32'd0} : {2'b00, acp_r, 22'd0};

  assign knee_s  = DIV_D_W'({cfg.knee, 14'd0});
  assign den_raw = (cmd.step == STEP_CGAIN) ? DIV_D_W'(car_r) + knee_s
                                            : DIV_D_W'(root_r) + knee_s;
  assign div_d   = (den_raw == '0) ? DIV_D_W'(1) : den_raw;
  assign div_n   = (cmd.step == STEP_CGAIN) ? {cfg.car_tgt, 39'd0}
                                            : {cfg.ac_tgt, 39'd0};

  assign is_inst = (cmd.step == STEP_SUMI) || (cmd.step == STEP_SUMQ) ||
                   (cmd.step == STEP_ABS);

  amed_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && ((cmd.step == STEP_CAR) || (cmd.step == STEP_DCA) ||
                          (cmd.step == STEP_SQ) || (cmd.step == STEP_ACP) ||
                          (cmd.step == STEP_OUT))),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  amed_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && ((cmd.step == STEP_MAG) || (cmd.step == STEP_ROOT))),
    .x     (rt_x),
    .done  (rt_done),
    .root  (rt_root)
  );

  amed_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && ((cmd.step == STEP_CGAIN) || (cmd.step == STEP_AGAIN))),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (quo)
  );

  // Rounded averager step, result always lies between old state and target.
  assign sm_rnd  = prod[63:0] + 64'h80_0000;
  assign sm_step = sm_rnd[63:24];
  assign sm_new  = dir_r ? sm_s + sm_step : sm_s - sm_step;

  assign sq_rnd  = {1'b0, prod[79:0]} + (81'd1 << 37);
  assign sq_q    = sq_rnd[80:38];

  assign out_rnd = {1'b0, prod} + ((PROD_W+1)'(1) << 38);
  assign out_q   = out_rnd[PROD_W:39];
  assign out_lim = neg_r ? 16'h8000 : 16'h7FFF;
  assign out_mag = (out_q > (PROD_W-38)'(out_lim)) ? out_lim : out_q[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_r       <= STATE_ONE;
      dca_r       <= STATE_ONE;
      acp_r       <= STATE_ONE;
      inst_done_r <= 1'b0;
    end else begin
      inst_done_r <= cmd.start && is_inst;
      if (mul_done) begin
        case (cmd.step)
          STEP_CAR: car_r <= sm_new;
          STEP_DCA: dca_r <= sm_new;
          STEP_ACP: acp_r <= sm_new;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ai_r <= in_phase[SAMPLE_W-1] ? SAMPLE_W'(-in_phase) : in_phase;
      aq_r <= quadrature[SAMPLE_W-1] ? SAMPLE_W'(-quadrature) : quadrature;
      be_r <= block_end;
    end
    if (cmd.start) begin
      case (cmd.step)
        STEP_SUMI: sum_r <= sq_val;
        STEP_SUMQ: sum_r <= sum_r + sq_val;
        STEP_ABS: begin
          neg_r    <= mag_r < dca_r;
          absval_r <= (mag_r < dca_r) ? dca_r - mag_r : mag_r - dca_r;
        end
        STEP_CAR, STEP_DCA, STEP_ACP: dir_r <= sm_up;
        default: ;
      endcase
    end
    if (mul_done) begin
      case (cmd.step)
        STEP_SQ:  sqv_r <= (sq_q[42:40] != 3'd0) ? '1 : sq_q[STATE_W-1:0];
        STEP_OUT: res_r <= neg_r ? SAMPLE_W'(-out_mag) : out_mag;
        default:  ;
      endcase
    end
    if (rt_done) begin
      if (cmd.step == STEP_MAG) begin
        mag_r <= STATE_W'({rt_root, 7'd0});
      end else begin
        root_r <= {1'b0, rt_root[RT_OUT_W-2:0], 8'd0};
      end
    end
    if (div_done) begin
      if (cmd.step == STEP_CGAIN) begin
        gain_c_r <= quo;
      end else begin
        gain_r <= (quo < gain_c_r) ? quo : gain_c_r;
      end
    end
  end

  assign done          = inst_done_r | mul_done | rt_done | div_done;
  assign audio_sample  = res_r;
  assign block_end_out = be_r;

  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({inst_done_r, mul_done, rt_done, div_done}))
    else $error("two arithmetic units finished in the same cycle");

  a_mul_step: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (cmd.step == STEP_CAR) || (cmd.step == STEP_DCA) ||
                 (cmd.step == STEP_SQ) || (cmd.step == STEP_ACP) ||
                 (cmd.step == STEP_OUT))
    else $error("multiplier finished outside a multiply step");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !cmd.start)
    else $error("step launched on two consecutive cycles");

endmodule
`default_nettype wire

// ----- design/am_envelope_detector_agc.sv -----
`default_nettype none
// AM envelope detector with AGC. Each input word is one complex baseband
// sample (I, Q in Q1.15); each output word is one saturated Q1.15 audio
// sample, exactly one per input, with block_end copied alongside. The work
// for an item is sequenced step by step through one shift-add multiplier
// (five products per item), one restoring square root unit (two roots per
// item) and one restoring divider (two gains per item), all retiring one
// bit per cycle. A finished result sits in the output register, so the next
// sample is accepted while it waits; the following result is held back only
// if that register is still full. Configuration registers (index 0 to 5:
// DC-removal weight, carrier weight, AC-power weight, carrier target, AC
// target, knee) are always ready and should be written while no sample is
// in flight; unknown indexes are ignored. The three averager states reset
// to 1.0.
module am_envelope_detector_agc
  import amed_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SAMPLE_W-1:0]   in_phase,
  input  wire logic [SAMPLE_W-1:0]   in_quadrature,
  input  wire logic                  in_block_end,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_W-1:0]        out_audio_sample,
  output logic                       out_block_end_out,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                cfg_r;
  ctrl_stat_t          stat;
  ctrl_out_t           ctl;
  dp_cmd_t             cmd;
  logic                dp_done;
  logic [SAMPLE_W-1:0] dp_audio;
  logic                dp_be;
  logic                in_fire;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_audio_r;
  logic                out_be_r;

  assign cfg_ready = 1'b1;

  // Register file; narrower registers keep only their low bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dc_coef  <= 24'd167772;
      cfg_r.car_coef <= 24'd3355;
      cfg_r.ac_coef  <= 24'd3355;
      cfg_r.car_tgt  <= 15'd16384;
      cfg_r.ac_tgt   <= 15'd3277;
      cfg_r.knee     <= 24'd16777;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DC_COEF:  cfg_r.dc_coef  <= cfg_data;
        CFG_CAR_COEF: cfg_r.car_coef <= cfg_data;
        CFG_AC_COEF:  cfg_r.ac_coef  <= cfg_data;
        CFG_CAR_TGT:  cfg_r.car_tgt  <= cfg_data[TGT_W-1:0];
        CFG_AC_TGT:   cfg_r.ac_tgt   <= cfg_data[TGT_W-1:0];
        CFG_KNEE:     cfg_r.knee     <= cfg_data;
        default:      ;
      endcase
    end
  end

  // The input is open only while the sequencer is idle.
  assign in_stall      = !ctl.in_ready;
  assign in_fire       = in_valid && ctl.in_ready;
  assign stat.in_fire  = in_fire;
  assign stat.out_free = !out_valid_r || !out_stall;

  amed_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .stat    (stat),
    .dp_done (dp_done),
    .cmd     (cmd),
    .ctl     (ctl)
  );

  amed_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .load          (in_fire),
    .in_phase      (in_phase),
    .quadrature    (in_quadrature),
    .block_end     (in_block_end),
    .cmd           (cmd),
    .done          (dp_done),
    .audio_sample  (dp_audio),
    .block_end_out (dp_be)
  );

  // Output register: filled when a result is ready, emptied when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.result_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.result_load) begin
      out_audio_r <= dp_audio;
      out_be_r    <= dp_be;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_audio_sample  = out_audio_r;
  assign out_block_end_out = out_be_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.result_load |-> (!out_valid_r || !out_stall))
    else $error("result written over a word that was not taken");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("second word accepted while one is in flight");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.result_load |=> !ctl.result_load)
    else $error("one word delivered twice");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import amed_pkg::*;

  // Any index past the last register must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX_B = 3'd7;
  localparam longint CYCLE_LIMIT = 4_000_000;

  // Scoreboard: a fixed-point envelope/AGC predictor plus the queue of
  // audio words it has predicted but not yet seen leave the block.
  class agc_scoreboard;
    logic [23:0] dc_coef, car_coef, ac_coef, knee_reg;
    logic [14:0] car_tgt, ac_tgt;
    logic [63:0] carrier_lvl, dc_avg, ac_pwr;
    logic [15:0] audio_q[$];
    logic        flag_q[$];
    int          errors;

    function void reset_state();
      dc_coef = 24'd167772;
      car_coef = 24'd3355;
      ac_coef = 24'd3355;
      car_tgt = 15'd16384;
      ac_tgt = 15'd3277;
      knee_reg = 24'd16777;
      carrier_lvl = 64'(STATE_ONE);
      dc_avg = 64'(STATE_ONE);
      ac_pwr = 64'(STATE_ONE);
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (cfg_idx_t'(idx))
        CFG_DC_COEF:  dc_coef = data;
        CFG_CAR_COEF: car_coef = data;
        CFG_AC_COEF:  ac_coef = data;
        CFG_CAR_TGT:  car_tgt = data[14:0];
        CFG_AC_TGT:   ac_tgt = data[14:0];
        CFG_KNEE:     knee_reg = data;
        default: ;
      endcase
    endfunction

    // Rounded (a*b) >> sh over the full product, clipped at lim.
    function logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int sh,
                                      logic [63:0] lim);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << (sh - 1));
      p = p >> sh;
      return (p > {64'd0, lim}) ? lim : p[63:0];
    endfunction

    function logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= r + bitv) begin
          x = x - (r + bitv);
          r = (r >> 1) + bitv;
        end else begin
          r = r >> 1;
        end
        bitv = bitv >> 2;
      end
      return r;
    endfunction

    function logic [63:0] average(logic [63:0] s, logic [63:0] x, logic [23:0] c);
      logic [63:0] smax;
      smax = (64'd1 << STATE_W) - 1;
      if (x >= s) return s + scale_round(x - s, 64'(c), 24, smax);
      return s - scale_round(s - x, 64'(c), 24, smax);
    endfunction

    function logic [63:0] gain(logic [14:0] tgt, logic [63:0] den);
      if (den == 0) den = 1;
      return (64'(tgt) << 39) / den;
    endfunction

    function void note_input(logic [15:0] i, logic [15:0] q, logic be);
      longint      si, sq;
      logic [63:0] sum, mag, knee_s, car_gain, ac_gain, g, absval, lim, r, smax, sqv;
      logic        neg;
      smax = (64'd1 << STATE_W) - 1;
      si = longint'($signed(i));
      sq = longint'($signed(q));
      if (si < 0) si = -si;
      if (sq < 0) sq = -sq;
      sum = 64'(si * si + sq * sq);
      mag = floor_root(sum << 32) << 7;
      if (mag > smax) mag = smax;
      carrier_lvl = average(carrier_lvl, mag, car_coef);
      dc_avg = average(dc_avg, mag, dc_coef);
      knee_s = 64'(knee_reg) << 14;
      car_gain = gain(car_tgt, carrier_lvl + knee_s);
      neg = mag < dc_avg;
      absval = neg ? dc_avg - mag : mag - dc_avg;
      sqv = scale_round(absval, absval, 38, smax);
      ac_pwr = average(ac_pwr, sqv, ac_coef);
      ac_gain = gain(ac_tgt, (floor_root(ac_pwr << 22) << 8) + knee_s);
      g = (ac_gain < car_gain) ? ac_gain : car_gain;
      lim = neg ? 64'd32768 : 64'd32767;
      r = scale_round(absval, g, 39, lim);
      if (neg) r = -r;
      audio_q.push_back(r[15:0]);
      flag_q.push_back(be);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check(logic [15:0] audio, logic be);
      logic [15:0] ea;
      logic        eb;
      if (audio_q.size() == 0) begin
        report($sformatf("unexpected audio word %h", audio));
      end else begin
        ea = audio_q.pop_front();
        eb = flag_q.pop_front();
        if (audio !== ea)
          report($sformatf("audio_sample got %h want %h", audio, ea));
        if (be !== eb)
          report($sformatf("block_end_out got %b want %b", be, eb));
      end
    endtask

    function int pending();
      return audio_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   in_phase = '0;
  logic [SAMPLE_W-1:0]   in_quadrature = '0;
  logic                  in_block_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   out_audio_sample;
  logic                  out_block_end_out;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  agc_scoreboard sb = new();
  int     send_idle;   // percent of cycles the sender holds back
  int     recv_idle;   // percent of cycles the receiver stalls
  longint cycles = 0;

  am_envelope_detector_agc dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("am_envelope_detector_agc verification failed");
      $finish;
    end
  end

  // Result side: values read here are the ones from before this edge, so a
  // word counts as taken when valid was high and stall was low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check(out_audio_sample, out_block_end_out);
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Offers one input word and holds it until accepted, then maybe idles.
  task send_word(logic [15:0] i, logic [15:0] q, logic be);
    in_valid <= 1'b1;
    in_phase <= i;
    in_quadrature <= q;
    in_block_end <= be;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(i, q, be);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // One register write; cfg_valid then drops before the task returns.
  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every predicted word to come back so the block is idle, then
  // wait longer so the output register can drain.
  task settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Random stimulus. Most words look like an AM signal: a carrier of a
  // slowly wandering level with a modulated envelope, carried on I or Q at
  // random sign with a small random part on the other. The rest is full-range noise.
  task random_words(int count);
    int level, amp, sgn;
    logic [15:0] i, q;
    level = $urandom_range(32767, 256);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(49) == 0) level = $urandom_range(32767, 16);
        amp = level + int'($urandom_range(level / 2)) - level / 4;
        if (amp > 32767) amp = 32767;
        sgn = $urandom_range(1) ? -1 : 1;
        i = 16'(sgn * amp);
        q = 16'(int'($urandom_range(amp / 4)) - amp / 8);
        if ($urandom_range(1)) {i, q} = {q, i};
      end else begin
        i = 16'($urandom);
        q = 16'($urandom);
      end
      send_word(i, q, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    sb.reset_state();
    send_idle = 30;
    recv_idle = 53;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners at reset settings: full-scale and zero samples in
    // every sign, then a step down so the envelope swings negative.
    send_word(16'h8000, 16'h8000, 1'b1);
    send_word(16'h7FFF, 16'h7FFF, 1'b0);
    send_word(16'h8000, 16'h7FFF, 1'b1);
    send_word(16'h0000, 16'h0000, 1'b0);
    send_word(16'h7FFF, 16'h0000, 1'b0);
    send_word(16'h0000, 16'h8000, 1'b1);
    send_word(16'h0001, 16'hFFFF, 1'b0);
    send_word(16'hAAAA, 16'h5555, 1'b0);
    send_word(16'h5555, 16'hAAAA, 1'b1);
    send_word(16'h0000, 16'h0000, 1'b0);
    random_words(290);
    settle();

    // Every weight at its largest, both targets at full scale written with
    // stray upper bits that must be masked, and the smallest legal knee.
    // Full-scale inputs then push the output into saturation.
    write_cfg(CFG_DC_COEF, 24'hFFFFFF);
    write_cfg(CFG_CAR_COEF, 24'hFFFFFF);
    write_cfg(CFG_AC_COEF, 24'hFFFFFF);
    write_cfg(CFG_CAR_TGT, 24'hFFFFFF);
    write_cfg(CFG_AC_TGT, 24'hFFFFFF);
    write_cfg(CFG_KNEE, 24'd1);
    write_cfg(UNUSED_IDX_A, 24'h123456);
    send_word(16'h7FFF, 16'h7FFF, 1'b0);
    send_word(16'h0000, 16'h0000, 1'b1);
    send_word(16'h8000, 16'h8000, 1'b0);
    send_word(16'h0000, 16'h0001, 1'b0);
    random_words(290);
    settle();

    send_idle = 53;
    recv_idle = 30;
    // Frozen averagers, zero targets and the largest knee.
    write_cfg(CFG_DC_COEF, 24'd0);
    write_cfg(CFG_CAR_COEF, 24'd0);
    write_cfg(CFG_AC_COEF, 24'd0);
    write_cfg(CFG_CAR_TGT, 24'd0);
    write_cfg(CFG_AC_TGT, 24'd0);
    write_cfg(CFG_KNEE, 24'hFFFFFF);
    random_words(300);
    settle();

    // Random settings throughout.
    write_cfg(CFG_DC_COEF, 24'($urandom));
    write_cfg(CFG_CAR_COEF, 24'($urandom_range(1 << 20)));
    write_cfg(CFG_AC_COEF, 24'($urandom_range(1 << 20)));
    write_cfg(CFG_CAR_TGT, 24'($urandom));
    write_cfg(CFG_AC_TGT, 24'($urandom));
    write_cfg(CFG_KNEE, 24'($urandom_range(1 << 18, 1)));
    write_cfg(UNUSED_IDX_B, 24'hFFFFFF);
    random_words(300);
    settle();

    send_idle = 0;
    recv_idle = 0;
    // A zero knee lets a gain denominator reach zero once the averagers
    // settle on silence, so a run of zero samples follows.
    write_cfg(CFG_DC_COEF, 24'hFFFFFF);
    write_cfg(CFG_CAR_COEF, 24'hFFFFFF);
    write_cfg(CFG_AC_COEF, 24'hFFFFFF);
    write_cfg(CFG_CAR_TGT, 24'd32767);
    write_cfg(CFG_AC_TGT, 24'd32767);
    write_cfg(CFG_KNEE, 24'd0);
    for (int n = 0; n < 8; n++) send_word(16'h0000, 16'h0000, n[0]);
    send_word(16'h0100, 16'h0000, 1'b0);
    random_words(290);
    settle();

    // Back to the power-up settings.
    write_cfg(CFG_DC_COEF, 24'd167772);
    write_cfg(CFG_CAR_COEF, 24'd3355);
    write_cfg(CFG_AC_COEF, 24'd3355);
    write_cfg(CFG_CAR_TGT, 24'd16384);
    write_cfg(CFG_AC_TGT, 24'd3277);
    write_cfg(CFG_KNEE, 24'd16777);
    random_words(340);
    settle();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("am_envelope_detector_agc verification clean");
    end else begin
      $display("am_envelope_detector_agc verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
